// ===== sv/itda_pkg.sv =====
// itda_pkg: shared types and constants for the integer to decimal ascii block
// no dependencies

package itda_pkg;

  localparam int ValueW    = 32;
  localparam int NumDigits = 10;
  localparam int BcdW      = 4 * NumDigits;
  localparam int IdxW      = 4;
  localparam int CharW     = 6;
  localparam int DabSteps  = 8;
  localparam int DabStages = ValueW / DabSteps;

  localparam logic [CharW-1:0] CodeMinus = 6'd45;
  localparam logic [1:0]       CodeDigitHi = 2'b11;
  localparam logic [IdxW-1:0]  MaxIdx = IdxW'(NumDigits - 1);

  typedef struct packed {
    logic              neg;
    logic [BcdW-1:0]   bcd;
    logic [ValueW-1:0] bin;
  } dd_t;

  typedef struct packed {
    logic            neg;
    logic [BcdW-1:0] bcd;
    logic [IdxW-1:0] idx;
  } emit_t;

endpackage

// ===== sv/itda_if.sv =====
// itda_in_if, itda_out_if: valid/ready channels for input values and output characters
// depends on itda_pkg

interface itda_in_if import itda_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface itda_out_if import itda_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             last;
  modport source (output valid, output char_code, output last, input ready);
  modport sink (input valid, input char_code, input last, output ready);
endinterface

// ===== sv/int_to_decimal_ascii_top.sv =====
// int_to_decimal_ascii_top: signed 32-bit integer to decimal ascii characters
// depends on itda_pkg, itda_if, itda_dabble, itda_lead, itda_emit
//
// Each input value comes out as 1 to 11 characters, a minus sign first for
// negative values, then the digits most significant first with no leading
// zeros, last set on the final one. A value passes an input register (sign and
// magnitude), four shift-add-3 stages of eight bits each, a leading digit
// stage and the character serializer. The serializer sends one character per
// cycle while the output is ready, and the next value's text follows without
// a gap; the pipeline keeps taking values until it is full.

module int_to_decimal_ascii_top import itda_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  itda_in_if.sink    in_ch,
  itda_out_if.source out_ch
);

  logic valid0_r;
  dd_t  data0_r;
  dd_t  data0_nxt;
  logic rdy0;

  logic [DabStages:0] st_valid;
  logic [DabStages:0] st_ready;
  dd_t                st_data [DabStages+1];

  logic  lead_valid;
  logic  lead_ready;
  emit_t lead_data;

  always_comb begin
    data0_nxt.neg = in_ch.value[ValueW-1];
    data0_nxt.bcd = '0;
    data0_nxt.bin = in_ch.value[ValueW-1] ? (ValueW'(0) - ValueW'(in_ch.value))
                                          : ValueW'(in_ch.value);
  end

  assign in_ch.ready = !valid0_r || rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      data0_r <= data0_nxt;
    end
  end

  assign st_valid[0] = valid0_r;
  assign st_data[0]  = data0_r;
  assign rdy0        = st_ready[0];

  for (genvar g = 0; g < DabStages; g++) begin : g_dab
    itda_dabble u_dab (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (st_valid[g]),
      .in_ready  (st_ready[g]),
      .in_data   (st_data[g]),
      .out_valid (st_valid[g+1]),
      .out_ready (st_ready[g+1]),
      .out_data  (st_data[g+1])
    );
  end

  itda_lead u_lead (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (st_valid[DabStages]),
    .in_ready  (st_ready[DabStages]),
    .in_data   (st_data[DabStages]),
    .out_valid (lead_valid),
    .out_ready (lead_ready),
    .out_data  (lead_data)
  );

  itda_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (lead_valid),
    .in_ready      (lead_ready),
    .in_data       (lead_data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_char_code (out_ch.char_code),
    .out_last      (out_ch.last)
  );

endmodule

// ===== sv/itda_dabble.sv =====
// itda_dabble: one pipeline stage of shift-add-3 binary to bcd conversion
// depends on itda_pkg

module itda_dabble import itda_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  dd_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output dd_t  out_data
);

  logic valid_r;
  dd_t  data_r;
  dd_t  data_nxt;

  always_comb begin
    logic [BcdW-1:0]   bcd;
    logic [ValueW-1:0] bin;
    bcd = in_data.bcd;
    bin = in_data.bin;
    for (int s = 0; s < DabSteps; s++) begin
      for (int d = 0; d < NumDigits; d++) begin
        if (bcd[d*4 +: 4] >= 4'd5) begin
          bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
        end
      end
      {bcd, bin} = {bcd[BcdW-2:0], bin, 1'b0};
    end
    data_nxt.neg = in_data.neg;
    data_nxt.bcd = bcd;
    data_nxt.bin = bin;
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== sv/itda_lead.sv =====
// itda_lead: pipeline stage that finds the most significant nonzero digit
// depends on itda_pkg

module itda_lead import itda_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  dd_t   in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output emit_t out_data
);

  logic  valid_r;
  emit_t data_r;
  emit_t data_nxt;

  always_comb begin
    data_nxt.neg = in_data.neg;
    data_nxt.bcd = in_data.bcd;
    data_nxt.idx = '0;
    for (int d = 1; d < NumDigits; d++) begin
      if (in_data.bcd[d*4 +: 4] != 4'd0) begin
        data_nxt.idx = IdxW'(d);
      end
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== sv/itda_emit.sv =====
// itda_emit: serializer that sends the sign and digits one character per cycle while out_ready is high
// depends on itda_pkg

module itda_emit import itda_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  emit_t            in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CharW-1:0] out_char_code,
  output logic             out_last
);

  logic            busy_r, busy_nxt;
  logic            neg_pend_r, neg_pend_nxt;
  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [BcdW-1:0] bcd_r;
  logic            out_fire;
  logic            in_fire;
  logic [3:0]      digit;

  assign digit         = bcd_r[idx_r*4 +: 4];
  assign out_valid     = busy_r;
  assign out_last      = !neg_pend_r && (idx_r == '0);
  assign out_char_code = neg_pend_r ? CodeMinus : {CodeDigitHi, digit};
  assign out_fire      = busy_r && out_ready;
  assign in_ready      = !busy_r || (out_ready && out_last);
  assign in_fire       = in_valid && in_ready;

  always_comb begin
    busy_nxt     = busy_r;
    neg_pend_nxt = neg_pend_r;
    idx_nxt      = idx_r;
    if (out_fire) begin
      if (neg_pend_r) begin
        neg_pend_nxt = 1'b0;
      end else if (out_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r - 1'b1;
      end
    end
    if (in_fire) begin
      busy_nxt     = 1'b1;
      neg_pend_nxt = in_data.neg;
      idx_nxt      = in_data.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      neg_pend_r <= 1'b0;
      idx_r      <= '0;
    end else begin
      busy_r     <= busy_nxt;
      neg_pend_r <= neg_pend_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      bcd_r <= in_data.bcd;
    end
  end

  a_neg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    neg_pend_r |-> busy_r)
    else $error("sign pending while idle");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> idx_r <= MaxIdx)
    else $error("digit index out of range");

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> busy_r && idx_r == $past(in_data.idx) && neg_pend_r == $past(in_data.neg))
    else $error("item not loaded");

  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !neg_pend_r && !out_last) |=> idx_r == $past(idx_r) - 1'b1)
    else $error("digit index did not step");

endmodule
